// File: rtl/tgla_pkg.sv
// Shared types, constants and register indexes of the text glyph layout addresser.
package tgla_pkg;

  // Default glyph geometry in pixels and bitmap bytes.
  localparam int DEF_GLYPH_HEIGHT = 16;
  localparam int DEF_GLYPH_WIDTH  = 16;
  localparam int DEF_GLYPH_BYTES  = 32;

  // Configuration register indexes.
  localparam logic [1:0] CFG_COLUMN_LIMIT = 2'd0;
  localparam logic [1:0] CFG_WIDE_BASE    = 2'd1;
  localparam logic [1:0] CFG_NARROW_BASE  = 2'd2;

  localparam logic [15:0] COLUMN_LIMIT_RESET = 16'd240;

  // Request codes.
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TEXT  = 1'b1;

  // Byte codes of the character set.
  localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] LEAD_FIRST     = 8'hA1;
  localparam logic [7:0] TRAIL_FIRST    = 8'hA1;
  localparam logic [7:0] ROW_A_END      = 8'hAA;
  localparam logic [7:0] ROW_B_FIRST    = 8'hB0;
  localparam logic [7:0] ROW_B_END      = 8'hF8;

  // GB2312 table layout.
  localparam int WIDE_ROW_SIZE     = 94;
  localparam int WIDE_ROW_B_OFFSET = 1410;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  text_byte;
    logic [15:0] start_row;
    logic [15:0] start_col;
  } in_item_t;

  typedef struct packed {
    logic [23:0] glyph_addr;
    logic [7:0]  glyph_len;
    logic        is_wide;
    logic [15:0] win_row0;
    logic [15:0] win_col0;
    logic [15:0] win_row1;
    logic [15:0] win_col1;
  } out_item_t;

endpackage

// File: rtl/tgla_addr_gen.sv
// Font flash address generation for wide (GB2312) and narrow (ASCII) glyphs.
module tgla_addr_gen #(
  parameter int GLYPH_BYTES = tgla_pkg::DEF_GLYPH_BYTES
) (
  input  logic [23:0] wide_base,
  input  logic [23:0] narrow_base,
  input  logic [7:0]  lead_byte,
  input  logic [7:0]  trail_byte,
  input  logic        is_wide,
  output logic [23:0] glyph_addr
);
  import tgla_pkg::*;

  localparam int HALF_BYTES = GLYPH_BYTES / 2;
  localparam int ROW_STRIDE = WIDE_ROW_SIZE * GLYPH_BYTES;
  localparam int ROW_B_BASE = WIDE_ROW_B_OFFSET * GLYPH_BYTES;

  logic [7:0]  row_a_idx;
  logic [7:0]  row_b_idx;
  logic [23:0] trail_term;
  logic [23:0] wide_off;
  logic [23:0] narrow_off;

  // Each term is a product with a constant, so the sums stay one level deep.
  assign row_a_idx  = lead_byte - LEAD_FIRST;
  assign row_b_idx  = lead_byte - ROW_B_FIRST;
  assign trail_term = (24'(trail_byte) - 24'(TRAIL_FIRST)) * 24'(GLYPH_BYTES);

  always_comb begin
    if (lead_byte < ROW_A_END) begin
      wide_off = 24'(row_a_idx) * 24'(ROW_STRIDE) + trail_term;
    end else if (lead_byte >= ROW_B_FIRST && lead_byte < ROW_B_END) begin
      wide_off = 24'(ROW_B_BASE) + 24'(row_b_idx) * 24'(ROW_STRIDE) + trail_term;
    end else begin
      wide_off = '0;
    end
  end

  // Bytes below the space character wrap around modulo 2^24.
  assign narrow_off = (24'(trail_byte) - 24'(CHAR_SPACE)) * 24'(HALF_BYTES);

  assign glyph_addr = is_wide ? (wide_base + wide_off) : (narrow_base + narrow_off);

endmodule

// File: rtl/text_glyph_layout_addresser.sv
// Top level of the text glyph layout addresser: cursor state, registers and result queue.
//
// The block turns a byte stream of mixed ASCII and GB2312 text into one result per
// glyph: the flash address and length of its bitmap and the screen window it covers.
// Input channel (in_valid/in_ready/in_data): a start transfer (req_type 0) sets the
// cursor and the line origin and drops a pending lead byte; a text transfer (req_type 1)
// delivers one byte. A lead byte of 0xA1 or more and a newline give no result.
// Result channel (out_valid/out_ready/out_data): one result per narrow glyph or per
// completed wide glyph, in input order.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; the user
// must make writes only while the block is idle; the block itself does not enforce this.
// Indexes beyond the register list are ignored. Each result is registered.
// Throughput is one item per cycle while in_ready is high; all work is one combinational
// pass between the cursor registers and the result register.
// When the receiver stalls, a second result is caught in a skid register and in_ready
// drops only while that skid register is full, so no result is lost.
// Reset (rst_n low, synchronous) clears the cursor, the lead state and the valid flags of
// both result registers, and sets column_limit to 240 and both font bases to zero.
module text_glyph_layout_addresser #(
  parameter int GLYPH_HEIGHT = tgla_pkg::DEF_GLYPH_HEIGHT,
  parameter int GLYPH_WIDTH  = tgla_pkg::DEF_GLYPH_WIDTH,
  parameter int GLYPH_BYTES  = tgla_pkg::DEF_GLYPH_BYTES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tgla_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tgla_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [23:0]         cfg_data
);
  import tgla_pkg::*;

  localparam logic [15:0] WIDE_SPAN   = 16'(GLYPH_HEIGHT);
  localparam logic [15:0] NARROW_SPAN = 16'(GLYPH_HEIGHT / 2);
  localparam logic [15:0] ROW_STEP    = 16'(GLYPH_WIDTH);
  localparam logic [7:0]  WIDE_LEN    = 8'(GLYPH_BYTES);
  localparam logic [7:0]  NARROW_LEN  = 8'(GLYPH_BYTES / 2);

  // Configuration registers.
  logic [15:0] column_limit_r;
  logic [23:0] wide_base_r;
  logic [23:0] narrow_base_r;

  // Cursor and lead byte state.
  logic [15:0] cursor_row_r, cursor_row_nxt;
  logic [15:0] cursor_col_r, cursor_col_nxt;
  logic [15:0] origin_col_r, origin_col_nxt;
  logic [7:0]  lead_byte_r, lead_byte_nxt;
  logic        lead_pending_r, lead_pending_nxt;

  // Result register and skid register.
  out_item_t   out_item_r;
  logic        out_valid_r;
  out_item_t   skid_item_r;
  logic        skid_valid_r;

  logic        in_fire;
  logic        out_fire;
  logic        is_text;
  logic        col_over;
  logic        wrap;
  logic [15:0] row_eff;
  logic [15:0] col_eff;
  logic        emit;
  logic        emit_wide;
  logic [15:0] span;
  logic [23:0] glyph_addr;
  out_item_t   result;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // The wrap test is skipped for the second byte of a wide glyph.
  assign is_text  = (in_data.req_type == REQ_TEXT);
  assign col_over = ({1'b0, cursor_col_r} + 17'(GLYPH_HEIGHT)) > {1'b0, column_limit_r};
  assign wrap     = is_text && !lead_pending_r &&
                    (col_over || in_data.text_byte == CHAR_NEWLINE);
  assign row_eff  = wrap ? (cursor_row_r + ROW_STEP) : cursor_row_r;
  assign col_eff  = wrap ? origin_col_r : cursor_col_r;

  assign emit_wide = lead_pending_r;
  assign span      = emit_wide ? WIDE_SPAN : NARROW_SPAN;

  tgla_addr_gen #(
    .GLYPH_BYTES (GLYPH_BYTES)
  ) u_addr_gen (
    .wide_base   (wide_base_r),
    .narrow_base (narrow_base_r),
    .lead_byte   (lead_byte_r),
    .trail_byte  (in_data.text_byte),
    .is_wide     (emit_wide),
    .glyph_addr  (glyph_addr)
  );

  always_comb begin
    result.glyph_addr = glyph_addr;
    result.glyph_len  = emit_wide ? WIDE_LEN : NARROW_LEN;
    result.is_wide    = emit_wide;
    result.win_row0   = row_eff;
    result.win_col0   = col_eff;
    result.win_row1   = row_eff + (ROW_STEP - 16'd1);
    result.win_col1   = col_eff + (span - 16'd1);
  end

  // Next cursor state for an accepted item.
  always_comb begin
    cursor_row_nxt   = cursor_row_r;
    cursor_col_nxt   = cursor_col_r;
    origin_col_nxt   = origin_col_r;
    lead_byte_nxt    = lead_byte_r;
    lead_pending_nxt = lead_pending_r;
    emit             = 1'b0;
    if (in_fire) begin
      if (!is_text) begin
        cursor_row_nxt   = in_data.start_row;
        cursor_col_nxt   = in_data.start_col;
        origin_col_nxt   = in_data.start_col;
        lead_pending_nxt = 1'b0;
      end else if (lead_pending_r) begin
        // Any trail byte completes the wide glyph.
        lead_pending_nxt = 1'b0;
        cursor_col_nxt   = cursor_col_r + WIDE_SPAN;
        emit             = 1'b1;
      end else begin
        cursor_row_nxt = row_eff;
        cursor_col_nxt = col_eff;
        if (in_data.text_byte == CHAR_NEWLINE) begin
          emit = 1'b0;
        end else if (in_data.text_byte >= LEAD_FIRST) begin
          lead_byte_nxt    = in_data.text_byte;
          lead_pending_nxt = 1'b1;
        end else begin
          cursor_col_nxt = col_eff + NARROW_SPAN;
          emit           = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_limit_r <= COLUMN_LIMIT_RESET;
      wide_base_r    <= '0;
      narrow_base_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COLUMN_LIMIT: column_limit_r <= cfg_data[15:0];
        CFG_WIDE_BASE:    wide_base_r    <= cfg_data;
        CFG_NARROW_BASE:  narrow_base_r  <= cfg_data;
        default:          column_limit_r <= column_limit_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_row_r   <= '0;
      cursor_col_r   <= '0;
      origin_col_r   <= '0;
      lead_byte_r    <= '0;
      lead_pending_r <= 1'b0;
    end else begin
      cursor_row_r   <= cursor_row_nxt;
      cursor_col_r   <= cursor_col_nxt;
      origin_col_r   <= origin_col_nxt;
      lead_byte_r    <= lead_byte_nxt;
      lead_pending_r <= lead_pending_nxt;
    end
  end

  // Two-entry result queue. The skid register only fills while the result register
  // is stalled, and it always drains into the result register first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_fire || !out_valid_r) begin
      if (skid_valid_r) begin
        out_item_r   <= skid_item_r;
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_item_r  <= result;
        out_valid_r <= emit;
      end
    end else if (emit) begin
      skid_item_r  <= result;
      skid_valid_r <= 1'b1;
    end
  end

  // The skid register never holds a result while the result register is empty.
  assert property (@(posedge clk) disable iff (!rst_n) skid_valid_r |-> out_valid_r)
    else $error("skid register full while result register empty");

  // A start transfer always drops a pending lead byte.
  assert property (@(posedge clk) disable iff (!rst_n)
      (in_fire && in_data.req_type == REQ_START) |=> !lead_pending_r)
    else $error("lead byte still pending after start transfer");

  // A lead byte taken outside a wide glyph leaves the block waiting for its trail byte.
  assert property (@(posedge clk) disable iff (!rst_n)
      (in_fire && is_text && !lead_pending_r && in_data.text_byte >= LEAD_FIRST)
      |=> (lead_pending_r && !skid_valid_r || lead_pending_r))
    else $error("lead byte not held");

  // Result length follows the glyph kind.
  assert property (@(posedge clk) disable iff (!rst_n)
      out_valid_r |-> (out_item_r.glyph_len == (out_item_r.is_wide ? WIDE_LEN : NARROW_LEN)))
    else $error("glyph length does not match glyph kind");

  // A stalled result with a second one arriving must block the input side.
  assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid_r && !out_ready && emit) |=> !in_ready)
    else $error("input still ready with both result registers full");

endmodule
